/* rtl/core/cua_pkg.sv */
// Package: payload structs and codes for the contiguous unit allocator.
package cua_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] POL_BEST  = 2'd0;
    localparam logic [1:0] POL_WORST = 2'd1;
    localparam logic [1:0] POL_FIRST = 2'd2;

    localparam logic [0:0] CFG_POLICY = 1'b0;
    localparam logic [0:0] CFG_ACTIVE = 1'b1;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] owner_id;
        logic [10:0] amount;
    } t_in_beat;

    typedef struct packed {
        logic        status;
        logic [9:0]  start_unit;
        logic [10:0] units_released;
        logic [31:0] allocations_done;
        logic [31:0] units_granted_total;
        logic [31:0] frees_done;
        logic [31:0] units_released_total;
        logic [10:0] free_units;
        logic [10:0] smallest_hole;
        logic [10:0] largest_hole;
        logic [31:0] failures_total;
        logic [9:0]  hole_count;
    } t_out_beat;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

/* rtl/core/contiguous_unit_allocator_core.sv */
// Top level: owner memory, scan sequencer, hole tracker and counters.
// Each item scans the n effective units (S_SCAN, S_LAST) and decides (S_DEC); a granted
// allocate then writes the owner into each granted unit (S_WRITE) before S_OUT. The next beat
// is accepted only after the result is published, so one item is processed at a time, each
// sweeping every active unit through the single read port of the owner memory. A finished
// result may wait in the output register while the next item runs. Reset: a clearing pass
// zeroes every owner before the first beat; counters and config at once.
module contiguous_unit_allocator_core
    import cua_pkg::*;
#(
    parameter int MEM_UNITS  = 1024,
    parameter int OWNER_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int CW = ($clog2(MEM_UNITS + 1) > 11) ? $clog2(MEM_UNITS + 1) : 11;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_LAST  = 7'b0001000,
        S_DEC   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [OWNER_BITS-1:0] r_mem [MEM_UNITS];
    logic [OWNER_BITS-1:0] r_rd;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [OWNER_BITS-1:0] mem_wd;

    logic [1:0]  r_policy;
    logic [10:0] r_active;
    t_in_beat    r_req;
    logic [CW-1:0] r_idx;       // read address counter
    logic [CW-1:0] r_pos;       // unit whose data is in r_rd
    logic          r_rdv;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_wcnt;
    logic [AW-1:0] r_at;

    // hole tracking
    logic [CW-1:0] r_hstart, r_hlen, r_free, r_small, r_large;
    logic [CW-1:0] r_holes;
    logic          r_hbest, r_hworst, r_hfirst;
    logic [CW-1:0] r_bstart, r_blen, r_wstart, r_wlen, r_fstart;
    logic [CW-1:0] r_rel;

    logic [31:0] r_alloc, r_gsum, r_fcnt, r_rsum, r_fail;
    logic        r_ov;
    t_out_beat   r_res;         // decided result, waiting for the output register
    t_out_beat   r_out;
    t_out_beat   n_res, n_out;

    logic [OWNER_BITS-1:0] own;
    logic [CW-1:0] amt;
    logic [CW:0]   act_ext;
    assign own = OWNER_BITS'(r_req.owner_id);
    assign act_ext = {{(CW+1-11){1'b0}}, r_active};
    assign amt = CW'(r_req.amount);

    // effective unit count
    logic [CW-1:0] eff_n;
    assign eff_n = (act_ext > (CW+1)'(MEM_UNITS)) ? CW'(MEM_UNITS) : CW'(act_ext);

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // current hole closes with the unit in r_rd
    logic          cur_free, close;
    logic [CW-1:0] len_now, st_now;
    assign cur_free = (r_rd == '0);
    assign len_now  = cur_free ? r_hlen + 1'b1 : r_hlen;
    assign st_now   = (cur_free && r_hlen == '0) ? r_pos : r_hstart;
    assign close    = (!cur_free || (r_pos + 1'b1 == r_n)) && (len_now != '0);
    logic fits;
    assign fits = (r_req.operation == OP_ALLOC) && (len_now >= amt);

    // decision in S_DEC
    logic          grant;
    logic [CW-1:0] g_at;
    always_comb begin
        grant = 1'b0;
        g_at  = '0;
        if (own != '0 && amt != '0 && amt <= r_n) begin
            case (r_policy)
                POL_BEST:  begin grant = r_hbest;  g_at = r_bstart; end
                POL_WORST: begin grant = r_hworst; g_at = r_wstart; end
                POL_FIRST: begin grant = r_hfirst; g_at = r_fstart; end
                default:   grant = 1'b0;
            endcase
        end
    end

    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_idx[AW-1:0];
        mem_wd  = '0;
        mem_ra  = r_idx[AW-1:0];
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == CW'(MEM_UNITS - 1)) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (r_idx + 1'b1 >= r_n) n_state = S_LAST;
            S_LAST: n_state = S_DEC;
            S_DEC:  n_state = (r_req.operation == OP_ALLOC && grant) ? S_WRITE : S_OUT;
            S_WRITE: begin
                mem_we = 1'b1;
                mem_wa = r_at;
                mem_wd = own;
                if (r_wcnt <= CW'(1) || r_at == AW'(MEM_UNITS - 1)) n_state = S_OUT;
            end
            S_OUT: if (!r_ov || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // free: clear the matching owner once its read data is in r_rd
        if ((r_state == S_SCAN || r_state == S_LAST) && r_rdv
            && r_req.operation == OP_FREE && own != '0 && r_rd == own) begin
            mem_we = 1'b1;
            mem_wa = r_pos[AW-1:0];
            mem_wd = '0;
        end
    end

    // result fields decided at the end of the scan
    always_comb begin
        n_res = '0;
        n_res.status = 1'b1;
        case (r_req.operation)
            OP_ALLOC: begin
                if (grant) begin
                    n_res.status     = 1'b0;
                    n_res.start_unit = 10'(g_at);
                end
            end
            OP_FREE: begin
                n_res.units_released = 11'(r_rel);
                if (r_rel != '0) n_res.status = 1'b0;
            end
            OP_QUERY: begin
                n_res.status        = 1'b0;
                n_res.free_units    = 11'(r_free);
                n_res.smallest_hole = 11'(r_small);
                n_res.largest_hole  = 11'(r_large);
                n_res.hole_count    = 10'(r_holes);
            end
            default: ;
        endcase
    end

    // output beat: decided fields plus the counters after this item
    always_comb begin
        n_out = r_res;
        n_out.allocations_done     = r_alloc;
        n_out.units_granted_total  = r_gsum;
        n_out.frees_done           = r_fcnt;
        n_out.units_released_total = r_rsum;
        n_out.failures_total       = r_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_policy <= POL_BEST;
            r_active <= 11'd1024;
            r_alloc  <= '0;
            r_gsum   <= '0;
            r_fcnt   <= '0;
            r_rsum   <= '0;
            r_fail   <= '0;
            r_ov     <= 1'b0;
            r_rdv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_POLICY) r_policy <= i_cfg_data[1:0];
                else r_active <= i_cfg_data;
            end
            r_rdv <= (r_state == S_SCAN) && (r_idx < r_n);
            case (r_state)
                S_CLEAR: r_idx <= r_idx + 1'b1;
                S_IDLE: if (i_valid) begin
                    r_req  <= i_data;
                    r_n    <= eff_n;
                    r_idx  <= '0;
                    r_pos  <= '0;
                    r_hlen <= '0;  r_hstart <= '0;
                    r_free <= '0;  r_small <= '0; r_large <= '0; r_holes <= '0;
                    r_hbest <= 1'b0; r_hworst <= 1'b0; r_hfirst <= 1'b0;
                    r_bstart <= '0; r_blen <= '0; r_wstart <= '0; r_wlen <= '0;
                    r_fstart <= '0; r_rel <= '0;
                end
                S_SCAN: r_idx <= r_idx + 1'b1;
                default: ;
            endcase
            // hole tracking on read data
            if ((r_state == S_SCAN || r_state == S_LAST) && r_rdv) begin
                r_pos <= r_pos + 1'b1;
                if (r_req.operation == OP_FREE && own != '0 && r_rd == own)
                    r_rel <= r_rel + 1'b1;
                if (close) begin
                    r_hlen  <= '0;
                    r_holes <= r_holes + 1'b1;
                    r_free  <= r_free + len_now;
                    if (r_holes == '0 || len_now < r_small) r_small <= len_now;
                    if (len_now > r_large) r_large <= len_now;
                    if (fits && amt != '0) begin
                        if (!r_hbest || len_now <= r_blen) begin
                            r_hbest <= 1'b1; r_blen <= len_now; r_bstart <= st_now;
                        end
                        if (!r_hworst || len_now > r_wlen) begin
                            r_hworst <= 1'b1; r_wlen <= len_now; r_wstart <= st_now;
                        end
                        if (!r_hfirst) begin
                            r_hfirst <= 1'b1; r_fstart <= st_now;
                        end
                    end
                end else begin
                    r_hlen   <= len_now;
                    r_hstart <= st_now;
                end
            end
            // decide, update counters and hold the result
            if (r_state == S_DEC) begin
                r_res <= n_res;
                case (r_req.operation)
                    OP_ALLOC: begin
                        if (grant) begin
                            r_at    <= g_at[AW-1:0];
                            r_wcnt  <= amt;
                            r_alloc <= sat_add(r_alloc, 32'd1);
                            r_gsum  <= sat_add(r_gsum, 32'(amt));
                        end else begin
                            r_fail <= sat_add(r_fail, 32'd1);
                        end
                    end
                    OP_FREE: begin
                        if (r_rel != '0) begin
                            r_fcnt <= sat_add(r_fcnt, 32'd1);
                            r_rsum <= sat_add(r_rsum, 32'(r_rel));
                        end else begin
                            r_fail <= sat_add(r_fail, 32'd1);
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_WRITE) begin
                r_at   <= r_at + 1'b1;
                r_wcnt <= r_wcnt - 1'b1;
            end
            // publish the result once the output register is free
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov  <= 1'b1;
                r_out <= n_out;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_data)) else $error("stalled result changed");
    a_write_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_req.operation == OP_ALLOC && own != '0))
        else $error("write without grant");
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid) else $error("result during clear");

endmodule
